// ===== src/opfd_pkg.sv =====
`default_nettype none
package opfd_pkg;

	localparam int TIME_W   = 32;
	localparam int DUR_W    = 16;
	localparam int CNT_W    = 7;
	localparam int SUM_W    = 22;
	localparam int BITS_W   = 64;
	localparam int IDX_W    = $clog2(BITS_W);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MAX_FRAME_PULSES = 64;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// divider step counter, one quotient bit per step
	localparam int DIV_STEP_W = $clog2(SUM_W);

	localparam logic [TIME_W-1:0] FRAME_GAP_RST  = TIME_W'(5000);
	localparam logic [DUR_W-1:0]  NOISE_MIN_RST  = DUR_W'(100);
	localparam logic [CNT_W-1:0]  MIN_FRAME_RST  = CNT_W'(8);
	localparam logic [DUR_W-1:0]  SHORT_LOW_RST  = DUR_W'(250);
	localparam logic [DUR_W-1:0]  SHORT_HIGH_RST = DUR_W'(550);
	localparam logic [DUR_W-1:0]  LONG_LOW_RST   = DUR_W'(850);
	localparam logic [DUR_W-1:0]  LONG_HIGH_RST  = DUR_W'(1400);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_GAP,
		CFG_NOISE_MIN,
		CFG_MIN_FRAME,
		CFG_SHORT_LOW,
		CFG_SHORT_HIGH,
		CFG_LONG_LOW,
		CFG_LONG_HIGH
	} cfg_idx_t;

	// one entry per accepted edge, handed from front to back
	typedef struct packed {
		logic              frame;
		logic [CNT_W-1:0]  count;
		logic [BITS_W-1:0] bits;
		logic [SUM_W-1:0]  long_sum;
		logic [SUM_W-1:0]  short_sum;
		logic [CNT_W-1:0]  long_cnt;
		logic [CNT_W-1:0]  short_cnt;
		logic              malformed;
		logic              pair_fail;
	} rec_t;

	typedef struct packed {
		logic              frame_ready;
		logic [CNT_W-1:0]  pulse_count;
		logic              drop;
		logic [BITS_W-1:0] pulse_bits;
		logic [DUR_W-1:0]  long_avg;
		logic [DUR_W-1:0]  short_avg;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} bk_state_t;

endpackage
`default_nettype wire

// ===== src/ook_pulse_frame_decoder.sv =====
// Path: an accepted edge is registered as a delta, passes the queue and is loaded into the
//   result register; a well-formed frame with both classes first runs the two dividers.
// Flow: the front takes no new edge until the last one is pushed to the queue; a frame
//   needing averages holds the back while the dividers run, buffered by a 2-deep queue.
// Reset: arst_n asynchronous, active low; config returns to defaults, frame state,
//   queue and result valid flag clear, and the block accepts at once.
`default_nettype none
module ook_pulse_frame_decoder (
	input  wire                              clk,
	input  wire                              arst_n,
	// edge words in
	input  wire                              push,
	output logic                             full,
	input  wire  [opfd_pkg::TIME_W-1:0]      edge_time_us,
	// result words out
	input  wire                              pop,
	output logic                             empty,
	output logic                             frame_ready,
	output logic [opfd_pkg::CNT_W-1:0]       pulse_count,
	output logic                             drop,
	output logic [opfd_pkg::BITS_W-1:0]      pulse_bits,
	output logic [opfd_pkg::DUR_W-1:0]       long_avg_us,
	output logic [opfd_pkg::DUR_W-1:0]       short_avg_us,
	// config writes
	input  wire                              cfg_write,
	input  wire  [opfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [opfd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import opfd_pkg::*;

	// Front: delta, classify, accumulate; emits one record word per edge.
	// Queue: decouples the front from the back while the dividers run.
	// Back: averages via iterative dividers, then a one-word result register.
	rec_t f_rec, q_dout;
	logic f_push, q_full, q_empty, q_pop;
	logic res_valid;
	res_t res;

	opfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.edge_time_us (edge_time_us),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_full       (q_full),
		.q_push       (f_push),
		.q_rec        (f_rec)
	);

	opfd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_rec),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	opfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rec     (q_dout),
		.q_pop     (q_pop),
		.pop       (pop),
		.res_valid (res_valid),
		.res       (res)
	);

	// result word is the back's output register
	assign empty        = !res_valid;
	assign frame_ready  = res.frame_ready;
	assign pulse_count  = res.pulse_count;
	assign drop         = res.drop;
	assign pulse_bits   = res.pulse_bits;
	assign long_avg_us  = res.long_avg;
	assign short_avg_us = res.short_avg;

endmodule
`default_nettype wire

// ===== src/opfd_fifo.sv =====
`default_nettype none
module opfd_fifo (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire opfd_pkg::rec_t din,
	output logic                full,
	input  wire                 pop,
	output opfd_pkg::rec_t      dout,
	output logic                empty
);
	import opfd_pkg::*;

	rec_t               entries_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
		ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
	endfunction

	assign full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + Q_CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - Q_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= din;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== src/opfd_front.sv =====
`default_nettype none
module opfd_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push,
	output logic                             full,
	input  wire  [opfd_pkg::TIME_W-1:0]      edge_time_us,
	input  wire                              cfg_write,
	input  wire  [opfd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [opfd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                              q_full,
	output logic                             q_push,
	output opfd_pkg::rec_t                   q_rec
);
	import opfd_pkg::*;

	// config
	logic [TIME_W-1:0] gap_q;
	logic [DUR_W-1:0]  noise_q;
	logic [CNT_W-1:0]  min_q;
	logic [DUR_W-1:0]  s_lo_q, s_hi_q, l_lo_q, l_hi_q;

	// frame state
	logic [TIME_W-1:0] last_q;
	logic [CNT_W-1:0]  pulses_q;
	logic [BITS_W-1:0] bits_q;
	logic [SUM_W-1:0]  lsum_q, ssum_q;
	logic [CNT_W-1:0]  lcnt_q, scnt_q;
	logic              mal_q, pair_q, prev_long_q;

	logic              valid_s1;
	logic [TIME_W-1:0] delta_s1;

	logic [CNT_W-1:0]  pulses_n;
	logic [BITS_W-1:0] bits_n;
	logic [SUM_W-1:0]  lsum_n, ssum_n;
	logic [CNT_W-1:0]  lcnt_n, scnt_n;
	logic              mal_n, pair_n, prev_long_n;
	logic              clear;
	logic              is_gap, is_noise, in_long, in_short;
	logic [IDX_W-1:0]  idx;

	assign full   = valid_s1;
	assign q_push = valid_s1 && !q_full;
	assign idx    = pulses_q[IDX_W-1:0];

	assign is_gap   = delta_s1 > gap_q;
	assign is_noise = delta_s1 < TIME_W'(noise_q);
	assign in_long  = (delta_s1 >= TIME_W'(l_lo_q)) && (delta_s1 <= TIME_W'(l_hi_q));
	assign in_short = (delta_s1 >= TIME_W'(s_lo_q)) && (delta_s1 <= TIME_W'(s_hi_q));

	always_comb begin
		pulses_n    = pulses_q + CNT_W'(1);
		bits_n      = bits_q;
		lsum_n      = lsum_q;
		ssum_n      = ssum_q;
		lcnt_n      = lcnt_q;
		scnt_n      = scnt_q;
		mal_n       = mal_q;
		pair_n      = pair_q;
		prev_long_n = prev_long_q;
		clear       = 1'b0;
		q_rec       = '0;

		if (!mal_q) begin
			if (in_long) begin
				bits_n      = bits_q | (BITS_W'(1) << idx);
				lsum_n      = lsum_q + delta_s1[SUM_W-1:0];
				lcnt_n      = lcnt_q + CNT_W'(1);
			end else if (in_short) begin
				ssum_n      = ssum_q + delta_s1[SUM_W-1:0];
				scnt_n      = scnt_q + CNT_W'(1);
			end else begin
				mal_n       = 1'b1;
			end
			// odd pulse must differ from its even partner
			if (!mal_n && idx[0] && (prev_long_q == in_long))
				pair_n = 1'b1;
			prev_long_n = in_long;
		end

		if (is_gap) begin
			clear = 1'b1;
			if (pulses_q > min_q) begin
				q_rec.frame     = 1'b1;
				q_rec.count     = pulses_q;
				q_rec.bits      = bits_q;
				q_rec.long_sum  = lsum_q;
				q_rec.short_sum = ssum_q;
				q_rec.long_cnt  = lcnt_q;
				q_rec.short_cnt = scnt_q;
				q_rec.malformed = mal_q;
				q_rec.pair_fail = pair_q;
			end
		end else if (is_noise) begin
			clear = 1'b1;
		end else if (pulses_n >= CNT_W'(MAX_FRAME_PULSES)) begin
			clear           = 1'b1;
			q_rec.frame     = 1'b1;
			q_rec.count     = pulses_n;
			q_rec.bits      = bits_n;
			q_rec.long_sum  = lsum_n;
			q_rec.short_sum = ssum_n;
			q_rec.long_cnt  = lcnt_n;
			q_rec.short_cnt = scnt_n;
			q_rec.malformed = mal_n;
			q_rec.pair_fail = pair_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= FRAME_GAP_RST;
			noise_q     <= NOISE_MIN_RST;
			min_q       <= MIN_FRAME_RST;
			s_lo_q      <= SHORT_LOW_RST;
			s_hi_q      <= SHORT_HIGH_RST;
			l_lo_q      <= LONG_LOW_RST;
			l_hi_q      <= LONG_HIGH_RST;
			last_q      <= '0;
			valid_s1    <= 1'b0;
			pulses_q    <= '0;
			bits_q      <= '0;
			lsum_q      <= '0;
			ssum_q      <= '0;
			lcnt_q      <= '0;
			scnt_q      <= '0;
			mal_q       <= 1'b0;
			pair_q      <= 1'b0;
			prev_long_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FRAME_GAP:  gap_q   <= cfg_data[TIME_W-1:0];
					CFG_NOISE_MIN:  noise_q <= cfg_data[DUR_W-1:0];
					CFG_MIN_FRAME:  min_q   <= cfg_data[CNT_W-1:0];
					CFG_SHORT_LOW:  s_lo_q  <= cfg_data[DUR_W-1:0];
					CFG_SHORT_HIGH: s_hi_q  <= cfg_data[DUR_W-1:0];
					CFG_LONG_LOW:   l_lo_q  <= cfg_data[DUR_W-1:0];
					CFG_LONG_HIGH:  l_hi_q  <= cfg_data[DUR_W-1:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				last_q   <= edge_time_us;
				valid_s1 <= 1'b1;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
			if (q_push) begin
				if (clear) begin
					pulses_q    <= '0;
					bits_q      <= '0;
					lsum_q      <= '0;
					ssum_q      <= '0;
					lcnt_q      <= '0;
					scnt_q      <= '0;
					mal_q       <= 1'b0;
					pair_q      <= 1'b0;
					prev_long_q <= 1'b0;
				end else begin
					pulses_q    <= pulses_n;
					bits_q      <= bits_n;
					lsum_q      <= lsum_n;
					ssum_q      <= ssum_n;
					lcnt_q      <= lcnt_n;
					scnt_q      <= scnt_n;
					mal_q       <= mal_n;
					pair_q      <= pair_n;
					prev_long_q <= prev_long_n;
				end
			end
		end
	end

	// wrapping delta to the previous edge
	always_ff @(posedge clk) begin
		if (push && !full)
			delta_s1 <= edge_time_us - last_q;
	end

endmodule
`default_nettype wire

// ===== src/opfd_div.sv =====
`default_nettype none
module opfd_div (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire  [opfd_pkg::SUM_W-1:0]     dividend,
	input  wire  [opfd_pkg::CNT_W-1:0]     divisor,
	output logic                           busy,
	output logic [opfd_pkg::SUM_W-1:0]     quotient
);
	import opfd_pkg::*;

	logic                  busy_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [CNT_W-1:0]      div_q;
	logic [CNT_W-1:0]      rem_q;
	logic [SUM_W-1:0]      dq_q;

	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	// restoring, one quotient bit per cycle
	assign trial    = {rem_q, dq_q[SUM_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign busy     = busy_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + DIV_STEP_W'(1);
			if (step_q == DIV_STEP_W'(SUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			dq_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			dq_q  <= {dq_q[SUM_W-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ===== src/opfd_back.sv =====
`default_nettype none
module opfd_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_empty,
	input  wire opfd_pkg::rec_t q_rec,
	output logic                q_pop,
	input  wire                 pop,
	output logic                res_valid,
	output opfd_pkg::res_t      res
);
	import opfd_pkg::*;

	bk_state_t state_q, state_n;
	rec_t      rec_q;
	res_t      res_q, res_n;
	logic      valid_q;
	logic      out_free, load, div_start, need_div;
	logic      l_busy, s_busy;
	logic [SUM_W-1:0] l_quot, s_quot;

	assign out_free  = !valid_q || pop;
	assign need_div  = q_rec.frame && !q_rec.malformed &&
	                   (q_rec.long_cnt != '0) && (q_rec.short_cnt != '0);
	assign res_valid = valid_q;
	assign res       = res_q;

	opfd_div u_div_long (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_rec.long_sum),
		.divisor  (q_rec.long_cnt),
		.busy     (l_busy),
		.quotient (l_quot)
	);

	opfd_div u_div_short (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (q_rec.short_sum),
		.divisor  (q_rec.short_cnt),
		.busy     (s_busy),
		.quotient (s_quot)
	);

	always_comb begin
		state_n   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		load      = 1'b0;
		res_n     = '0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					q_pop = 1'b1;
					if (need_div) begin
						div_start = 1'b1;
						state_n   = BK_DIV;
					end else begin
						load = 1'b1;
						if (q_rec.frame) begin
							res_n.frame_ready = 1'b1;
							res_n.pulse_count = q_rec.count;
							res_n.drop        = 1'b1;
							res_n.pulse_bits  = q_rec.bits;
						end
					end
				end
			end
			BK_DIV: begin
				if (!l_busy && !s_busy && out_free) begin
					load              = 1'b1;
					res_n.frame_ready = 1'b1;
					res_n.pulse_count = rec_q.count;
					res_n.drop        = rec_q.pair_fail;
					res_n.pulse_bits  = rec_q.bits;
					res_n.long_avg    = l_quot[DUR_W-1:0];
					res_n.short_avg   = s_quot[DUR_W-1:0];
					state_n           = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load)
				valid_q <= 1'b1;
			else if (pop)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			rec_q <= q_rec;
		if (load)
			res_q <= res_n;
	end

endmodule
`default_nettype wire
